// ----- hw/rtl/skrt_pkg.sv -----
// Package for the sorted keyed record table: widths, operation and status
// codes, the cell command struct and the sequencer state type.
// Depends on nothing; every other file of the block imports it.
package skrt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int OP_W        = 2;
  localparam int KEY_W       = 24;
  localparam int DIG_W       = 4;
  localparam int REC_W       = 3 * DIG_W;
  localparam int STATUS_W    = 3;
  localparam int POS_W       = 6;
  localparam int COUNT_OUT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_DUP       = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_INVALID   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_DELETE
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } fsm_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [REC_W-1:0] digits;
  } record_t;

  // Broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic             cmp_en;
    logic [KEY_W-1:0] cmp_key;
    cell_cmd_t        cmd;
    record_t          new_rec;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/skrt_in_if.sv -----
// Input channel of the sorted keyed record table: valid/ready plus one item.
// Depends on skrt_pkg.
interface skrt_in_if;
  import skrt_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [KEY_W-1:0] key;
  logic [DIG_W-1:0] hundreds_digit;
  logic [DIG_W-1:0] tens_digit;
  logic [DIG_W-1:0] units_digit;

  modport source (output valid, operation, key, hundreds_digit, tens_digit, units_digit,
                  input ready);
  modport sink   (input valid, operation, key, hundreds_digit, tens_digit, units_digit,
                  output ready);
endinterface

// ----- hw/rtl/skrt_out_if.sv -----
// Result channel of the sorted keyed record table: valid/ready plus one item.
// Depends on skrt_pkg.
interface skrt_out_if;
  import skrt_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [POS_W-1:0]       position;
  logic [DIG_W-1:0]       found_hundreds;
  logic [DIG_W-1:0]       found_tens;
  logic [DIG_W-1:0]       found_units;
  logic [COUNT_OUT_W-1:0] entry_count;
  logic [KEY_W-1:0]       largest_key;

  modport source (output valid, status, position, found_hundreds, found_tens, found_units,
                         entry_count, largest_key,
                  input ready);
  modport sink   (input valid, status, position, found_hundreds, found_tens, found_units,
                        entry_count, largest_key,
                  output ready);
endinterface

// ----- hw/rtl/skrt_cell.sv -----
// One cell of the record chain: holds one record, compares its key against
// the broadcast key and shifts toward either neighbor. Depends on skrt_pkg.
module skrt_cell (
  input  logic                 clk,
  input  skrt_pkg::cell_ctrl_t ctrl,
  input  logic                 occ,
  input  skrt_pkg::record_t    left_rec,
  input  logic                 left_lt,
  input  skrt_pkg::record_t    right_rec,
  output skrt_pkg::record_t    rec,
  output logic                 lt,
  output logic                 eq
);
  import skrt_pkg::*;

  record_t rec_r, rec_nxt;
  logic    lt_r, eq_r;

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      lt_r <= occ && (rec_r.key < ctrl.cmp_key);
      eq_r <= occ && (rec_r.key == ctrl.cmp_key);
    end
    rec_r <= rec_nxt;
  end

  // Cells below the sorted place keep their record; the rest move one step.
  always_comb begin
    rec_nxt = rec_r;
    case (ctrl.cmd)
      CMD_INSERT: begin
        if (!lt_r) begin
          rec_nxt = left_lt ? ctrl.new_rec : left_rec;
        end
      end
      CMD_DELETE: begin
        if (!lt_r) begin
          rec_nxt = right_rec;
        end
      end
      default: rec_nxt = rec_r;
    endcase
  end

  assign rec = rec_r;
  assign lt  = lt_r;
  assign eq  = eq_r;

endmodule

// ----- hw/rtl/sorted_keyed_record_table_unit.sv -----
// Sorted keyed record table: a chain of TABLE_DEPTH cells keeps records in
// ascending key order. In the cycle an item is accepted every cell compares
// its key with the item's key; in the execute state the chain shifts in one
// step and the result is registered. The execute state waits while an earlier
// result has not been taken, and no new item is accepted until the previous
// one has executed. No clearing pass follows reset; the table is empty.
// Depends on skrt_pkg, skrt_in_if, skrt_out_if and skrt_cell.
module sorted_keyed_record_table_unit (
  input logic       clk,
  input logic       rst_n,
  skrt_in_if.sink   in_ch,
  skrt_out_if.source out_ch
);
  import skrt_pkg::*;

  fsm_t                   state_r, state_nxt;
  logic                   fire;
  logic                   in_ready;
  logic                   accept;

  op_t                    op_r;
  logic [KEY_W-1:0]       key_r;
  logic [REC_W-1:0]       digits_r;
  logic [KEY_W-1:0]       top1_r, top2_r;
  logic [KEY_W-1:0]       top1_sel, top2_sel;
  logic [CNT_W-1:0]       count_r, count_nxt;

  cell_ctrl_t             ctrl;
  record_t                cell_rec [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] lt_v, eq_v, occ_v, sel1_v, sel2_v, bnd_v;

  logic                   hit;
  logic                   full;
  logic [IDX_W-1:0]       pos_idx;
  logic [REC_W-1:0]       hit_digits;

  cell_cmd_t              cmd;
  status_t                status;
  logic [IDX_W-1:0]       pos;
  logic [REC_W-1:0]       found;
  logic [KEY_W-1:0]       largest;

  logic                   out_valid_r;
  status_t                status_r;
  logic [POS_W-1:0]       pos_r;
  logic [REC_W-1:0]       found_r;
  logic [COUNT_OUT_W-1:0] count_out_r;
  logic [KEY_W-1:0]       largest_r;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    fire      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // No item is taken while reset is held.
        in_ready = rst_n;
        if (in_ch.valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        fire = !out_valid_r || out_ch.ready;
        if (fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  // Chain of cells.
  assign ctrl.cmp_en          = accept;
  assign ctrl.cmp_key         = in_ch.key;
  assign ctrl.cmd             = fire ? cmd : CMD_HOLD;
  assign ctrl.new_rec.key     = key_r;
  assign ctrl.new_rec.digits  = digits_r;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    record_t left_rec, right_rec;
    logic    left_lt;

    if (i == 0) begin : g_first
      assign left_rec = '0;
      assign left_lt  = 1'b1;
      assign bnd_v[i] = !lt_v[i];
    end else begin : g_mid
      assign left_rec = cell_rec[i-1];
      assign left_lt  = lt_v[i-1];
      assign bnd_v[i] = !lt_v[i] && lt_v[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_rec = cell_rec[i];
    end else begin : g_inner
      assign right_rec = cell_rec[i+1];
    end

    assign occ_v[i]  = CNT_W'(i) < count_r;
    assign sel1_v[i] = (CNT_W'(i) + CNT_W'(1)) == count_r;
    assign sel2_v[i] = (CNT_W'(i) + CNT_W'(2)) == count_r;

    skrt_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (occ_v[i]),
      .left_rec  (left_rec),
      .left_lt   (left_lt),
      .right_rec (right_rec),
      .rec       (cell_rec[i]),
      .lt        (lt_v[i]),
      .eq        (eq_v[i])
    );
  end

  // Selections over the chain: the two topmost keys before the update, the
  // sorted place and the digits of the matching cell.
  always_comb begin
    top1_sel   = '0;
    top2_sel   = '0;
    pos_idx    = '0;
    hit_digits = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      top1_sel   = top1_sel | (cell_rec[i].key & {KEY_W{sel1_v[i]}});
      top2_sel   = top2_sel | (cell_rec[i].key & {KEY_W{sel2_v[i]}});
      pos_idx    = pos_idx | (IDX_W'(i) & {IDX_W{bnd_v[i]}});
      hit_digits = hit_digits | (cell_rec[i].digits & {REC_W{eq_v[i]}});
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= op_t'(in_ch.operation);
      key_r    <= in_ch.key;
      digits_r <= {in_ch.hundreds_digit, in_ch.tens_digit, in_ch.units_digit};
      top1_r   <= top1_sel;
      top2_r   <= top2_sel;
    end
  end

  assign hit  = |eq_v;
  assign full = count_r == CNT_W'(TABLE_DEPTH);

  // Outcome of the item held in the execute cycle.
  always_comb begin
    status    = STAT_OK;
    pos       = '0;
    found     = '0;
    cmd       = CMD_HOLD;
    count_nxt = count_r;
    largest   = top1_r;
    if (op_r != OP_NOP && key_r == '0) begin
      status = STAT_INVALID;
    end else begin
      unique case (op_r)
        OP_INSERT: begin
          if (hit) begin
            status = STAT_DUP;
            pos    = pos_idx;
          end else if (full) begin
            status = STAT_FULL;
          end else begin
            pos       = pos_idx;
            cmd       = CMD_INSERT;
            count_nxt = count_r + CNT_W'(1);
            if (CNT_W'(pos_idx) == count_r) begin
              largest = key_r;
            end
          end
        end
        OP_DELETE: begin
          if (!hit) begin
            status = STAT_NOT_FOUND;
          end else begin
            pos       = pos_idx;
            cmd       = CMD_DELETE;
            count_nxt = count_r - CNT_W'(1);
            if (CNT_W'(pos_idx) + CNT_W'(1) == count_r) begin
              largest = top2_r;
            end
          end
        end
        OP_LOOKUP: begin
          if (!hit) begin
            status = STAT_NOT_FOUND;
          end else begin
            pos   = pos_idx;
            found = hit_digits;
          end
        end
        OP_NOP: begin
          status = STAT_OK;
        end
        default: status = STAT_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r    <= status;
      pos_r       <= POS_W'(pos);
      found_r     <= found;
      count_out_r <= COUNT_OUT_W'(count_nxt);
      largest_r   <= largest;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = status_r;
  assign out_ch.position       = pos_r;
  assign out_ch.found_hundreds = found_r[REC_W-1 -: DIG_W];
  assign out_ch.found_tens     = found_r[DIG_W +: DIG_W];
  assign out_ch.found_units    = found_r[DIG_W-1:0];
  assign out_ch.entry_count    = count_out_r;
  assign out_ch.largest_key    = largest_r;

`ifndef SYNTHESIS
  // A result appears only after an execute cycle.
  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EXEC))
    else $error("result raised without an execute cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // The table is sorted, so the cells below the key form a prefix of the chain.
  a_lt_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXEC |-> ((lt_v >> 1) & ~lt_v) == '0)
    else $error("compare results are not a prefix");

  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXEC |-> $onehot0(eq_v))
    else $error("key stored in more than one cell");
`endif

endmodule
